@@ sv/t16st_pkg.sv @@
// ----------------------------------------------------------------------------
// t16st_pkg
// shared types and constants of the 16-bit thumb store unit
// ----------------------------------------------------------------------------
package t16st_pkg;

   localparam int REG_COUNT = 8;
   localparam int LIST_BITS = 8;
   localparam logic [7:0] LIST_MASK = 8'((1 << LIST_BITS) - 1);

   localparam logic [31:0] PC_STEP   = 32'd2;
   localparam logic [31:0] WORD_STEP = 32'd4;

   // memory access size codes
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   typedef enum logic [2:0] {
      CMD_LOAD = 3'd0,
      CMD_STR  = 3'd1,
      CMD_STRH = 3'd2,
      CMD_STRB = 3'd3,
      CMD_STM  = 3'd4
   } cmd_code_type;

   // controller to datapath
   typedef struct packed {
      logic idle;
      logic accept;
      logic addr_step;
      logic emit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_store;
      logic req_skip;
      logic out_free;
      logic done;
   } dp_sts_type;

endpackage

@@ sv/t16st_if.sv @@
// ----------------------------------------------------------------------------
// t16st request and response channels
// valid/ready channels carrying one request or one response item
// ----------------------------------------------------------------------------
interface t16st_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [2:0]  rt_index;
   logic [2:0]  rn_index;
   logic [2:0]  rm_index;
   logic [7:0]  reg_list;
   logic        in_it_block;
   logic        condition_passed;
   logic [31:0] load_value;

   modport source (
      output valid, command, rt_index, rn_index, rm_index, reg_list,
             in_it_block, condition_passed, load_value,
      input  ready
   );
   modport sink (
      input  valid, command, rt_index, rn_index, rm_index, reg_list,
             in_it_block, condition_passed, load_value,
      output ready
   );
endinterface

interface t16st_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_valid;
   logic [31:0] mem_address;
   logic [31:0] mem_data;
   logic [1:0]  mem_size;
   logic        it_advance;
   logic [31:0] pc_value;
   logic        last;

   modport source (
      output valid, write_valid, mem_address, mem_data, mem_size, it_advance,
             pc_value, last,
      input  ready
   );
   modport sink (
      input  valid, write_valid, mem_address, mem_data, mem_size, it_advance,
             pc_value, last,
      output ready
   );
endinterface

@@ sv/thumb16_store_unit.sv @@
// ----------------------------------------------------------------------------
// thumb16_store_unit
// executes 16-bit thumb stores against eight low registers and a pc
// ----------------------------------------------------------------------------
// Each request is one instruction. A register load (command 0) writes the
// register file in the accept cycle and gives no response; unused commands
// are dropped. Word, halfword and byte stores give one response once the
// request is accepted (accept with base and offset read, address add with
// source read, response register). A store-multiple of N listed registers
// gives N responses, the first through the same steps and then one per
// cycle while the response side takes them; the base register is written
// back with the last one. A store skipped inside a condition block, or a
// store-multiple with an empty list, gives a single response with no memory
// write, skipping the address add. One request is worked at a time; the
// register file has two read ports, which sets the address step. Ready
// returns as soon as the last response enters the output register, so the
// next request is taken while that response still waits. Every store, done
// or skipped, advances the pc by two; the pc shown is the value after it.
// ----------------------------------------------------------------------------
module thumb16_store_unit
   import t16st_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   t16st_req_if.sink   req_ch,
   t16st_rsp_if.source rsp_ch
);

   ctrl_cmd_type ctrl_cmd;
   dp_sts_type   dp_sts;

   // sequencer: owns ready and the step commands
   t16st_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .dp_sts    (dp_sts),
      .ctrl_cmd  (ctrl_cmd)
   );

   // datapath: register file, pc, list walk and response register
   t16st_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .ctrl_cmd             (ctrl_cmd),
      .dp_sts               (dp_sts),
      .req_command          (req_ch.command),
      .req_rt_index         (req_ch.rt_index),
      .req_rn_index         (req_ch.rn_index),
      .req_rm_index         (req_ch.rm_index),
      .req_reg_list         (req_ch.reg_list),
      .req_in_it_block      (req_ch.in_it_block),
      .req_condition_passed (req_ch.condition_passed),
      .req_load_value       (req_ch.load_value),
      .rsp_ready            (rsp_ch.ready),
      .rsp_valid            (rsp_ch.valid),
      .rsp_write_valid      (rsp_ch.write_valid),
      .rsp_mem_address      (rsp_ch.mem_address),
      .rsp_mem_data         (rsp_ch.mem_data),
      .rsp_mem_size         (rsp_ch.mem_size),
      .rsp_it_advance       (rsp_ch.it_advance),
      .rsp_pc_value         (rsp_ch.pc_value),
      .rsp_last             (rsp_ch.last)
   );

endmodule

@@ sv/t16st_ctrl.sv @@
// ----------------------------------------------------------------------------
// t16st_ctrl
// sequencer: request accept, address step, result issue
// ----------------------------------------------------------------------------
module t16st_ctrl
   import t16st_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_sts_type   dp_sts,
   output ctrl_cmd_type ctrl_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADDR,
      ST_EMIT
   } state_type;

   state_type state_ff;

   always_comb begin
      ctrl_cmd.idle      = (state_ff == ST_IDLE);
      ctrl_cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      ctrl_cmd.addr_step = (state_ff == ST_ADDR);
      ctrl_cmd.emit      = (state_ff == ST_EMIT) && dp_sts.out_free;
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && dp_sts.req_store) begin
                  // skipped or empty stores need no register reads
                  state_ff <= dp_sts.req_skip ? ST_EMIT : ST_ADDR;
               end
            end
            ST_ADDR: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (dp_sts.out_free && dp_sts.done) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ sv/t16st_dpath.sv @@
// ----------------------------------------------------------------------------
// t16st_dpath
// register file, pc, address unit, list walk and response register
// ----------------------------------------------------------------------------
module t16st_dpath
   import t16st_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type ctrl_cmd,
   output dp_sts_type   dp_sts,
   input  logic [2:0]   req_command,
   input  logic [2:0]   req_rt_index,
   input  logic [2:0]   req_rn_index,
   input  logic [2:0]   req_rm_index,
   input  logic [7:0]   req_reg_list,
   input  logic         req_in_it_block,
   input  logic         req_condition_passed,
   input  logic [31:0]  req_load_value,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output logic         rsp_write_valid,
   output logic [31:0]  rsp_mem_address,
   output logic [31:0]  rsp_mem_data,
   output logic [1:0]   rsp_mem_size,
   output logic         rsp_it_advance,
   output logic [31:0]  rsp_pc_value,
   output logic         rsp_last
);

   function automatic logic [2:0] lowest_set(input logic [7:0] bits);
      logic [2:0] idx;
      idx = '0;
      for (int i = 7; i >= 0; i--) begin
         if (bits[i]) idx = 3'(i);
      end
      return idx;
   endfunction

   function automatic logic [1:0] size_of(input cmd_code_type code);
      logic [1:0] size;
      unique case (code)
         CMD_STR:  size = SIZE_WORD;
         CMD_STRH: size = SIZE_HALF;
         CMD_STRB: size = SIZE_BYTE;
         default:  size = SIZE_WORD;
      endcase
      return size;
   endfunction

   // register file with reset-as-zero valid bits
   logic [31:0]          mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [31:0]          rd_a_ff;
   logic [31:0]          rd_b_ff;

   cmd_code_type req_code;
   cmd_code_type command_ff;
   logic [2:0]   rt_ff;
   logic [2:0]   rn_ff;
   logic         in_it_ff;
   logic         skip_ff;
   logic         stm_ff;
   logic [7:0]   rem_ff;
   logic [31:0]  addr_ff;
   logic [31:0]  pc_ff;
   logic         out_valid_ff;

   logic         req_is_store;
   logic         req_is_stm;
   logic [7:0]   req_sel;
   logic [7:0]   rem_next;
   logic         last_elem;
   logic [2:0]   rd_a_idx;
   logic         wr_en;
   logic [2:0]   wr_idx;
   logic [31:0]  wr_data;

   assign req_code     = cmd_code_type'(req_command);
   assign req_is_store = (req_code == CMD_STR) || (req_code == CMD_STRH) ||
                         (req_code == CMD_STRB) || (req_code == CMD_STM);
   assign req_is_stm   = (req_code == CMD_STM);
   assign req_sel      = req_reg_list & LIST_MASK;

   assign rem_next  = rem_ff & (rem_ff - 8'd1);
   assign last_elem = skip_ff || !stm_ff || (rem_next == 8'd0);

   always_comb begin
      dp_sts.req_store = req_is_store;
      dp_sts.req_skip  = (req_in_it_block && !req_condition_passed) ||
                         (req_is_stm && (req_sel == 8'd0));
      dp_sts.out_free  = !out_valid_ff || rsp_ready;
      dp_sts.done      = last_elem;
   end

   // read port a: base at accept, then source data (held while stalled)
   always_comb begin
      priority if (ctrl_cmd.idle) begin
         rd_a_idx = req_rn_index;
      end else if (ctrl_cmd.emit && stm_ff) begin
         rd_a_idx = lowest_set(rem_next);
      end else if (stm_ff) begin
         rd_a_idx = lowest_set(rem_ff);
      end else begin
         rd_a_idx = rt_ff;
      end
   end

   // single write port: register load, or base write-back after the list
   always_comb begin
      wr_en   = (ctrl_cmd.accept && (req_code == CMD_LOAD)) ||
                (ctrl_cmd.emit && stm_ff && !skip_ff && last_elem);
      wr_idx  = ctrl_cmd.accept ? req_rt_index : rn_ff;
      wr_data = ctrl_cmd.accept ? req_load_value : addr_ff + WORD_STEP;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      rd_a_ff <= vld_ff[rd_a_idx] ? mem_ff[rd_a_idx] : '0;
      rd_b_ff <= vld_ff[req_rm_index] ? mem_ff[req_rm_index] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.accept) begin
         command_ff <= req_code;
         rt_ff      <= req_rt_index;
         rn_ff      <= req_rn_index;
         in_it_ff   <= req_in_it_block;
         skip_ff    <= dp_sts.req_skip;
         stm_ff     <= req_is_stm;
         rem_ff     <= req_sel;
      end else if (ctrl_cmd.emit && stm_ff) begin
         rem_ff <= rem_next;
      end
      if (ctrl_cmd.addr_step) begin
         addr_ff <= stm_ff ? rd_a_ff : rd_a_ff + rd_b_ff;
      end else if (ctrl_cmd.emit && stm_ff) begin
         addr_ff <= addr_ff + WORD_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (ctrl_cmd.accept && req_is_store) begin
         pc_ff <= pc_ff + PC_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctrl_cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.emit) begin
         rsp_write_valid <= !skip_ff;
         rsp_mem_address <= skip_ff ? '0 : addr_ff;
         rsp_mem_data    <= skip_ff ? '0 : rd_a_ff;
         rsp_mem_size    <= skip_ff ? SIZE_BYTE : size_of(command_ff);
         rsp_it_advance  <= in_it_ff && last_elem;
         rsp_pc_value    <= pc_ff;
         rsp_last        <= last_elem;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

@@ sv/t16st_check.sv @@
// ----------------------------------------------------------------------------
// t16st_check
// port-level checks of the thumb store unit, bound to the top level
// ----------------------------------------------------------------------------
module t16st_check
   import t16st_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_write_valid,
   input logic [31:0] rsp_mem_address,
   input logic [31:0] rsp_mem_data,
   input logic [1:0]  rsp_mem_size,
   input logic        rsp_it_advance,
   input logic [31:0] rsp_pc_value,
   input logic        rsp_last
);

   // a response without a memory write is always a lone, zeroed response
   a_nowrite_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_valid) |->
         (rsp_last && (rsp_mem_address == 32'd0) && (rsp_mem_data == 32'd0) &&
          (rsp_mem_size == SIZE_BYTE)))
      else $error("response without write is not a zeroed last response");

   // only the last response of a request may carry the it advance
   a_mid_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |->
         (!rsp_it_advance && rsp_write_valid && (rsp_mem_size == SIZE_WORD)))
      else $error("store-multiple middle response malformed");

   // store-multiple responses follow at once, four bytes apart, same pc
   a_stm_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (rsp_valid && (rsp_pc_value == $past(rsp_pc_value)) &&
          (rsp_mem_address == $past(rsp_mem_address) + WORD_STEP)))
      else $error("store-multiple walk broken");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_mem_address) && $stable(rsp_mem_data) &&
          $stable(rsp_last) && $stable(rsp_pc_value)))
      else $error("stalled response changed");

endmodule

bind thumb16_store_unit t16st_check u_t16st_check (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_write_valid (rsp_ch.write_valid),
   .rsp_mem_address (rsp_ch.mem_address),
   .rsp_mem_data    (rsp_ch.mem_data),
   .rsp_mem_size    (rsp_ch.mem_size),
   .rsp_it_advance  (rsp_ch.it_advance),
   .rsp_pc_value    (rsp_ch.pc_value),
   .rsp_last        (rsp_ch.last)
);

@@ tb/sv/thumb16_store_unit_test.sv @@
// ----------------------------------------------------------------------------
// thumb16_store_unit_test
// self-checking bench for the 16-bit thumb store unit
// ----------------------------------------------------------------------------
// Requests go in on a valid/ready channel with random gaps. A shadow copy of
// the low registers and the pc is updated as each request is accepted, and
// the memory writes that the request must cause are queued. A checker takes
// every response, stalls at random between responses, and compares each one
// field by field with the oldest queued write. Directed tests cover the reset
// state, the field extremes, every command, skipped stores inside a
// condition block, empty and full store-multiple lists with the base in the
// list, and the unused command codes; random tests follow.
// ----------------------------------------------------------------------------
module thumb16_store_unit_test
   import t16st_pkg::*;
();

   // command codes the block must drop without effect
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   localparam int MAX_WAIT     = 14;
   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_CYCLES = 10;

   // one expected response of the store unit
   typedef struct packed {
      logic        write_valid;
      logic [31:0] mem_address;
      logic [31:0] mem_data;
      logic [1:0]  mem_size;
      logic        it_advance;
      logic [31:0] pc_value;
      logic        last;
   } mem_write_type;

   logic clock = 1'b0;
   logic reset;

   t16st_req_if req_ch ();
   t16st_rsp_if rsp_ch ();

   thumb16_store_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow architectural state, updated at request accept
   logic [31:0] shadow_regs [REG_COUNT];
   logic [31:0] shadow_pc;

   // memory writes still owed by the block, oldest first
   mem_write_type expected_writes [$];

   int mismatch_count = 0;
   bit no_idle = 1'b0;   // when set, neither side inserts gaps

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // gap before the next request or response, zero when no_idle is set
   function automatic int pick_wait();
      if (no_idle || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // register values, biased toward the wrap points
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFC;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return CMD_LOAD;
      if (r < 37) return CMD_STR;
      if (r < 49) return CMD_STRH;
      if (r < 61) return CMD_STRB;
      if (r < 95) return CMD_STM;
      return 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
   endfunction

   // executes one accepted request on the shadow state and queues its writes
   function automatic void execute_store(input logic [2:0] cmd, input logic [2:0] rt,
                                         input logic [2:0] rn, input logic [2:0] rm,
                                         input logic [7:0] list, input logic in_it,
                                         input logic pass, input logic [31:0] value);
      mem_write_type w;
      logic [7:0]    sel;
      logic [31:0]   addr;
      int            total;
      int            k;

      // register load fills the file and owes nothing
      if (cmd == CMD_LOAD) begin
         shadow_regs[rt] = value;
         return;
      end
      // unused codes are dropped
      if (cmd > CMD_STM)
         return;

      // every store advances the pc, done or skipped
      shadow_pc = shadow_pc + PC_STEP;
      sel = list & LIST_MASK;

      w = '0;
      w.pc_value   = shadow_pc;
      w.it_advance = in_it;
      w.last       = 1'b1;

      // skipped in a condition block, or empty list: one write-less response
      if ((in_it && !pass) || (cmd == CMD_STM && sel == 8'd0)) begin
         expected_writes.push_back(w);
         return;
      end

      if (cmd != CMD_STM) begin
         w.write_valid = 1'b1;
         w.mem_address = shadow_regs[rn] + shadow_regs[rm];
         w.mem_data    = shadow_regs[rt];
         w.mem_size    = (cmd == CMD_STR)  ? SIZE_WORD :
                         (cmd == CMD_STRH) ? SIZE_HALF : SIZE_BYTE;
         expected_writes.push_back(w);
         return;
      end

      // store multiple: ascending words, values taken before the write-back
      total = $countones(sel);
      addr  = shadow_regs[rn];
      k     = 0;
      for (int i = 0; i < REG_COUNT; i++) begin
         if (sel[i]) begin
            k++;
            w.write_valid = 1'b1;
            w.mem_address = addr;
            w.mem_data    = shadow_regs[i];
            w.mem_size    = SIZE_WORD;
            w.last        = (k == total);
            w.it_advance  = in_it && (k == total);
            expected_writes.push_back(w);
            addr = addr + WORD_STEP;
         end
      end
      shadow_regs[rn] = shadow_regs[rn] + WORD_STEP * 32'(total);
   endfunction

   // drives one request, waits for accept, then maybe idles
   // valid stays high on a zero gap so the next request follows at once
   task automatic send_request(input logic [2:0] cmd, input logic [2:0] rt,
                               input logic [2:0] rn, input logic [2:0] rm,
                               input logic [7:0] list, input logic in_it,
                               input logic pass, input logic [31:0] value);
      int gap;
      req_ch.command          <= cmd;
      req_ch.rt_index         <= rt;
      req_ch.rn_index         <= rn;
      req_ch.rm_index         <= rm;
      req_ch.reg_list         <= list;
      req_ch.in_it_block      <= in_it;
      req_ch.condition_passed <= pass;
      req_ch.load_value       <= value;
      req_ch.valid            <= 1'b1;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      execute_store(cmd, rt, rn, rm, list, in_it, pass, value);
      gap = pick_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // request of the given command with all other fields random
   task automatic send_random(input logic [2:0] cmd);
      send_request(cmd, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                   pick_value());
   endtask

   // response side: random stalls, compare with the oldest expected write
   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   initial begin : response_checker
      int            stall_left;
      mem_write_type exp_w;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_writes.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, got addr %h",
                        $time, rsp_ch.mem_address);
               mismatch_count++;
            end else begin
               exp_w = expected_writes.pop_front();
               check_field("write_valid", 32'(exp_w.write_valid), 32'(rsp_ch.write_valid));
               check_field("mem_address", exp_w.mem_address, rsp_ch.mem_address);
               check_field("mem_data", exp_w.mem_data, rsp_ch.mem_data);
               check_field("mem_size", 32'(exp_w.mem_size), 32'(rsp_ch.mem_size));
               check_field("it_advance", 32'(exp_w.it_advance), 32'(rsp_ch.it_advance));
               check_field("pc_value", exp_w.pc_value, rsp_ch.pc_value);
               check_field("last", 32'(exp_w.last), 32'(rsp_ch.last));
            end
            stall_left = pick_wait();
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_ch.ready <= !reset && (stall_left == 0);
      end
   end

   // ---------------------------------------------------------------- tests

   // registers and pc start at zero
   task automatic test_reset_state();
      send_request(CMD_STR, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0, 32'h0);
      send_request(CMD_STM, 3'd0, 3'd0, 3'd0, 8'h01, 1'b0, 1'b0, 32'h0);
   endtask

   // word, halfword and byte stores at the index and value extremes
   task automatic test_single_stores();
      send_request(CMD_LOAD, 3'd1, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF);
      send_request(CMD_LOAD, 3'd2, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0, 32'h0000_0001);
      send_request(CMD_LOAD, 3'd7, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0, 32'h8000_0000);
      // address wraps to zero
      send_request(CMD_STR,  3'd7, 3'd1, 3'd2, 8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
      send_request(CMD_STRH, 3'd1, 3'd7, 3'd7, 8'h00, 1'b0, 1'b0, 32'h0);
      send_request(CMD_STRB, 3'd2, 3'd7, 3'd1, 8'h55, 1'b0, 1'b1, 32'h0);
   endtask

   // full list with the base inside it, empty list, lowest and highest bit
   task automatic test_store_multiple();
      send_request(CMD_LOAD, 3'd2, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0, 32'h0000_0100);
      send_request(CMD_STM, 3'd0, 3'd2, 3'd0, 8'hFF, 1'b0, 1'b0, 32'h0);
      send_request(CMD_STM, 3'd7, 3'd2, 3'd7, 8'h00, 1'b0, 1'b1, 32'hFFFF_FFFF);
      send_request(CMD_STM, 3'd0, 3'd7, 3'd0, 8'h80, 1'b0, 1'b0, 32'h0);
      send_request(CMD_STM, 3'd0, 3'd1, 3'd0, 8'h01, 1'b0, 1'b0, 32'h0);
   endtask

   // condition block: taken and skipped stores, condition outside a block
   task automatic test_condition_block();
      send_request(CMD_STR,  3'd3, 3'd1, 3'd2, 8'h00, 1'b1, 1'b1, 32'h0);
      send_request(CMD_STRH, 3'd3, 3'd1, 3'd2, 8'h00, 1'b1, 1'b0, 32'h0);
      send_request(CMD_STM,  3'd0, 3'd2, 3'd0, 8'h0F, 1'b1, 1'b0, 32'h0);
      send_request(CMD_STM,  3'd0, 3'd2, 3'd0, 8'hA5, 1'b1, 1'b1, 32'h0);
      send_request(CMD_STRB, 3'd6, 3'd2, 3'd1, 8'h00, 1'b0, 1'b1, 32'h0);
      send_request(CMD_STR,  3'd6, 3'd2, 3'd1, 8'h00, 1'b0, 1'b0, 32'h0);
   endtask

   // unused codes change nothing, then a store shows the state untouched
   task automatic test_unused_commands();
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
         send_request(3'(c), 3'd1, 3'd1, 3'd2, 8'hFF, 1'b0, 1'b1, 32'hDEAD_BEEF);
      send_request(CMD_STR, 3'd1, 3'd1, 3'd2, 8'h00, 1'b0, 1'b0, 32'h0);
   endtask

   // broad mix of all commands with random fields
   task automatic test_random_mix();
      repeat (300) send_random(pick_command());
   endtask

   // store-multiple runs from one base so write-back accumulates
   task automatic test_stm_chains();
      logic [2:0] base;
      repeat (20) begin
         base = 3'($urandom_range(0, 7));
         send_request(CMD_LOAD, base, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)), 1'b0, 1'b0, pick_value());
         repeat ($urandom_range(3, 4))
            send_request(CMD_STM, 3'($urandom_range(0, 7)), base,
                         3'($urandom_range(0, 7)), 8'($urandom_range(1, 255)),
                         1'($urandom_range(0, 4) == 0), 1'($urandom_range(0, 3) != 0),
                         $urandom);
         // occasional interleaved single store or noise
         if ($urandom_range(0, 2) == 0)
            send_random(pick_command());
      end
   endtask

   // no gaps on either side: back-to-back requests and responses
   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (80) send_random(pick_command());
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------- main

   initial begin
      reset                   <= 1'b1;
      req_ch.valid            <= 1'b0;
      req_ch.command          <= CMD_LOAD;
      req_ch.rt_index         <= 3'd0;
      req_ch.rn_index         <= 3'd0;
      req_ch.rm_index         <= 3'd0;
      req_ch.reg_list         <= 8'h00;
      req_ch.in_it_block      <= 1'b0;
      req_ch.condition_passed <= 1'b0;
      req_ch.load_value       <= 32'h0;
      for (int i = 0; i < REG_COUNT; i++)
         shadow_regs[i] = 32'h0;
      shadow_pc = 32'h0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_single_stores();
      test_store_multiple();
      test_condition_block();
      test_unused_commands();
      test_random_mix();
      test_stm_chains();
      test_back_to_back();

      req_ch.valid <= 1'b0;

      // wait for every owed write, then a few cycles for strays
      while (expected_writes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_writes.size() == 0 && mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
